>>> hw/rtl/fip_pkg.sv
// Shared types and constants for the flat IOMMU page table.
// Used by fip_datapath, fip_ctrl and flat_iommu_page_table; no dependencies.
package fip_pkg;

	// Field widths fixed by the command format
	localparam int ADDR_W = 48;
	localparam int LEN_W  = 32;
	localparam int PERM_W = 12;
	localparam int CFG_W  = 11;
	localparam int KIND_W = 2;

	// Defaults for the top-level parameters
	localparam int DEF_TABLE_PAGES = 1024;
	localparam int DEF_PAGE_BITS   = 12;

	// Active page count after reset
	localparam logic [CFG_W-1:0] ACTIVE_RST = 11'd1024;

	// Command codes
	localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNMAP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REVOKE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic load;       // latch an input beat
		logic rd;         // read present bit at current index
		logic wr_map;     // write a present entry at current index
		logic wr_zero;    // clear entry at current index
		logic step;       // advance index, count and physical page
		logic res_load;   // load the output register
		logic res_status; // value to load
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              aligned;
		logic              rem_zero;
		logic              in_range;
		logic              present;
		logic              clr_last;
	} dp_stat_t;

endpackage

>>> hw/rtl/fip_datapath.sv
// Datapath of the flat IOMMU page table: command registers, page walk counters
// and the entry memory. Depends on fip_pkg.
module fip_datapath #(
	parameter int TABLE_PAGES = fip_pkg::DEF_TABLE_PAGES,
	parameter int PAGE_BITS   = fip_pkg::DEF_PAGE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fip_pkg::KIND_W-1:0]        kind,
	input  logic [fip_pkg::ADDR_W-1:0]        device_address,
	input  logic [fip_pkg::ADDR_W-1:0]        phys_address,
	input  logic [fip_pkg::LEN_W-1:0]         byte_length,
	input  logic [fip_pkg::PERM_W-1:0]        permission,
	input  logic                              cfg_we,
	input  logic [fip_pkg::CFG_W-1:0]         active_pages,
	input  fip_pkg::dp_cmd_t                  cmd,
	output fip_pkg::dp_stat_t                 stat,
	output logic                              status
);
	import fip_pkg::*;

	localparam int IDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int CNT_W = $clog2(TABLE_PAGES + 1);
	localparam int CUR_W = ADDR_W - PAGE_BITS + 1;
	localparam int REM_W = LEN_W - PAGE_BITS;
	localparam int PPG_W = ADDR_W - PAGE_BITS;
	localparam int ENT_W = ADDR_W;

	logic [CFG_W-1:0]  active_q;
	logic [KIND_W-1:0] kind_q;
	logic [CUR_W-1:0]  cur_q;
	logic [REM_W-1:0]  rem_q;
	logic [PPG_W-1:0]  ppg_q;
	logic [PERM_W-1:0] perm_q;
	logic [CNT_W-1:0]  lim_q;
	logic              aligned_q;
	logic              rd_q;
	logic              status_q;
	logic [CNT_W-1:0]  lim_d;
	logic              aligned_d;
	logic [IDX_W-1:0]  widx;
	logic [ENT_W-1:0]  entry;

	// Entry memory: present bit on top of the 48-bit entry
	logic [ENT_W:0] mem_q [TABLE_PAGES];

	// Active count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			active_q <= active_pages;
		end
	end

	// Active count saturates at the table size
	assign lim_d = (32'(active_q) > 32'(TABLE_PAGES)) ? CNT_W'(TABLE_PAGES) : CNT_W'(active_q);

	// Page alignment; physical address only matters for map
	assign aligned_d = (device_address[PAGE_BITS-1:0] == '0) &&
	                   (byte_length[PAGE_BITS-1:0] == '0) &&
	                   ((kind != KIND_MAP) || (phys_address[PAGE_BITS-1:0] == '0));

	// Walk index: reset starts the clearing pass at entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.load) begin
			cur_q <= (kind == KIND_REVOKE) ? '0 : {1'b0, device_address[ADDR_W-1:PAGE_BITS]};
		end else if (cmd.step) begin
			cur_q <= cur_q + 1'b1;
		end
	end

	// Command payload and walk counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			rem_q     <= byte_length[LEN_W-1:PAGE_BITS];
			ppg_q     <= phys_address[ADDR_W-1:PAGE_BITS];
			perm_q    <= permission;
			lim_q     <= lim_d;
			aligned_q <= aligned_d;
		end else if (cmd.step) begin
			rem_q <= rem_q - 1'b1;
			ppg_q <= ppg_q + 1'b1;
		end
	end

	assign widx  = cur_q[IDX_W-1:0];
	assign entry = {ppg_q, {PAGE_BITS{1'b0}}} | ENT_W'(perm_q);

	// Memory port: one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_map) begin
			mem_q[widx] <= {1'b1, entry};
		end else if (cmd.wr_zero) begin
			mem_q[widx] <= '0;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[widx][ENT_W];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
		end
	end

	assign status = status_q;

	// Status back to the controller
	assign stat.kind     = kind_q;
	assign stat.aligned  = aligned_q;
	assign stat.rem_zero = (rem_q == '0);
	assign stat.in_range = (cur_q < CUR_W'(lim_q));
	assign stat.present  = rd_q;
	assign stat.clr_last = (cur_q == CUR_W'(TABLE_PAGES - 1));

endmodule

>>> hw/rtl/fip_ctrl.sv
// Controller of the flat IOMMU page table: sequences clearing, map, unmap and
// revoke walks and owns the handshakes. Depends on fip_pkg.
module fip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fip_pkg::dp_stat_t stat,
	output fip_pkg::dp_cmd_t  cmd
);
	import fip_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_EVAL   = 3'd4;
	localparam logic [2:0] ST_REVOKE = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       fail_q, fail_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		fail_d         = fail_q;
		cmd            = '0;
		cmd.res_status = fail_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr_zero = 1'b1;
				cmd.step    = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.kind)
					KIND_MAP, KIND_UNMAP: begin
						if (stat.aligned) begin
							state_d = ST_CHECK;
						end else begin
							fail_d  = 1'b1;
							state_d = ST_DONE;
						end
					end
					KIND_REVOKE: state_d = ST_REVOKE;
					default: begin
						fail_d  = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_CHECK: begin
				if (stat.rem_zero) begin
					fail_d  = 1'b0;
					state_d = ST_DONE;
				end else if (!stat.in_range) begin
					fail_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// Map needs a free entry, unmap a present one
				if ((stat.kind == KIND_MAP) == stat.present) begin
					fail_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.wr_map  = (stat.kind == KIND_MAP);
					cmd.wr_zero = (stat.kind != KIND_MAP);
					cmd.step    = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_REVOKE: begin
				if (stat.in_range) begin
					cmd.wr_zero = 1'b1;
					cmd.step    = 1'b1;
				end else begin
					fail_d  = 1'b0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, result flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fail_q  <= fail_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/flat_iommu_page_table.sv
// Flat IOMMU page table. After reset the block clears all TABLE_PAGES entries
// before taking the first command; configuration writes are taken at
// any time. A map or unmap does a read-modify-write on the single entry
// memory port for each page, stopping early at a failing page; revoke does
// one memory write per active entry; misaligned or unknown commands fail
// without a walk. The result waits in an output register, and the next
// command is taken while it waits. Depends on fip_pkg, fip_ctrl and
// fip_datapath.
module flat_iommu_page_table #(
	parameter int TABLE_PAGES = fip_pkg::DEF_TABLE_PAGES,
	parameter int PAGE_BITS   = fip_pkg::DEF_PAGE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fip_pkg::KIND_W-1:0] kind,
	input  logic [fip_pkg::ADDR_W-1:0] device_address,
	input  logic [fip_pkg::ADDR_W-1:0] phys_address,
	input  logic [fip_pkg::LEN_W-1:0]  byte_length,
	input  logic [fip_pkg::PERM_W-1:0] permission,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       status,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fip_pkg::CFG_W-1:0]  active_pages
);
	import fip_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Register writes are always accepted
	assign cfg_ready = 1'b1;

	fip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fip_datapath #(
		.TABLE_PAGES (TABLE_PAGES),
		.PAGE_BITS   (PAGE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.device_address (device_address),
		.phys_address   (phys_address),
		.byte_length    (byte_length),
		.permission     (permission),
		.cfg_we         (cfg_valid),
		.active_pages   (active_pages),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status)
	);

endmodule
